### rtl/core/stq_pkg.sv
// Shared types, codes and constants of the software timer queue core.
// No dependencies; every other file of the core imports this package.
`timescale 1ns / 1ps

package stq_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int JUMP_GUARD      = 10;
    localparam int MAX_FIRES       = 16;
    localparam int FIRE_W          = $clog2(MAX_FIRES + 1);

    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_RUN      = 2'd1;
    localparam logic [1:0] OP_EXPIRE   = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic [1:0] KIND_SCHED    = 2'd0;
    localparam logic [1:0] KIND_FIRED    = 2'd1;
    localparam logic [1:0] KIND_RUN_DONE = 2'd2;
    localparam logic [1:0] KIND_EXP_DONE = 2'd3;

    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [4:0] RM_CNT_MAX = 5'd31;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ticks;
        logic [30:0] delay;
        logic [7:0]  callback_id;
        logic [15:0] context_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  callback_id_out;
        logic [15:0] context_id_out;
        logic [31:0] time_value;
        logic        is_earliest;
        logic        pending;
        logic [1:0]  status;
        logic [4:0]  removed_count;
        logic        last;
    } rsp_t;

    // One stored timer.
    typedef struct packed {
        logic [7:0]  callback_id;
        logic [15:0] context_id;
        logic [31:0] due;
        logic [31:0] set_time;
    } entry_t;

    // Per-slot outcome of the shared compare unit.
    typedef struct packed {
        logic        key_hit;
        logic        ctx_hit;
        logic        earlier;
        logic [31:0] order_key;
    } cmp_res_t;

endpackage

### rtl/core/stq_store.sv
// Timer table storage: entry memory with one write and one registered read
// port, plus per-slot valid flags. Depends on stq_pkg.
`timescale 1ns / 1ps

module stq_store
    import stq_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [SLOT_W-1:0]      wr_idx,
    input  entry_t                 wr_data,
    input  logic [SLOT_W-1:0]      rd_idx,
    output entry_t                 rd_data,
    input  logic                   clr_en,
    input  logic [SLOT_W-1:0]      clr_idx,
    output logic [TIMER_SLOTS-1:0] valid
);

    entry_t mem [TIMER_SLOTS];
    entry_t rd_data_reg;
    logic [TIMER_SLOTS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    // A write always claims a free slot, so it never meets a clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[clr_idx] <= 1'b0;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

### rtl/core/stq_cmp.sv
// Shared per-slot compare unit: key and context match, and the signed
// distance order key checked against the best key so far. Depends on stq_pkg.
`timescale 1ns / 1ps

module stq_cmp
    import stq_pkg::*;
(
    input  entry_t      ent,
    input  logic [31:0] now_ticks,
    input  logic [7:0]  callback_id,
    input  logic [15:0] context_id,
    input  logic [31:0] best_key,
    output cmp_res_t    res
);

    logic [31:0] due_dist;

    always_comb
    begin
        // Biasing the signed distance lets an unsigned compare order it.
        due_dist      = ent.due - now_ticks;
        res.order_key = due_dist ^ 32'h8000_0000;
        res.earlier   = res.order_key < best_key;
        res.ctx_hit   = ent.context_id == context_id;
        res.key_hit   = res.ctx_hit && (ent.callback_id == callback_id);
    end

endmodule

### rtl/core/software_timer_queue_core.sv
// Top level of the software timer queue: command sequencer that walks the
// timer table through the shared compare unit. Depends on stq_pkg,
// stq_store and stq_cmp.
`timescale 1ns / 1ps
//
//  Channel   Ports                 Direction  Transfer rule
//  --------  --------------------  ---------  ---------------------------------
//  command   start, busy, cmd      in         start high while busy is low
//  result    strobe, rsp           out        every cycle that strobe is high
//
//  Schedule, run and expire commands walk all TIMER_SLOTS table entries, one
//  entry per cycle, through the single compare unit; the entry memory read is
//  registered. A run command starts a fresh walk after each timer that
//  fires, and at most MAX_FIRES timers fire in one run. The unused opcode
//  is accepted and produces nothing.
//  Reset clears all valid flags at once; the entry memory is not cleared.
//  Results are shown for exactly one cycle on strobe; the receiver cannot
//  stall them, so busy alone paces the block.

module software_timer_queue_core
    import stq_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic strobe,
    output rsp_t rsp
);

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
    localparam logic [CNT_W-1:0]  SLOT_CNT  = CNT_W'(TIMER_SLOTS);
    localparam logic [FIRE_W-1:0] FIRE_LIM  = FIRE_W'(MAX_FIRES);
    localparam logic [31:0]       GUARD     = 32'(JUMP_GUARD);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCHED_END,
        S_RUN_CHECK,
        S_EXP_END
    } state_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                pipe_vld_reg;
    logic [SLOT_W-1:0]   pipe_idx_reg;
    logic                have_best_reg;
    logic [SLOT_W-1:0]   best_slot_reg;
    logic [31:0]         best_key_reg;
    entry_t              best_ent_reg;
    logic                found_reg;
    logic [SLOT_W-1:0]   found_slot_reg;
    logic                free_reg;
    logic [SLOT_W-1:0]   free_slot_reg;
    logic [4:0]          rm_cnt_reg;
    logic [FIRE_W-1:0]   fires_reg;
    logic                strobe_reg;
    rsp_t                rsp_reg;

    entry_t                 rd_data;
    logic [TIMER_SLOTS-1:0] valid;
    cmp_res_t               res;
    logic                   slot_v;
    logic [30:0]            delay_eff;
    logic [31:0]            when_ticks;
    logic [31:0]            new_key;
    logic                   new_earliest;
    logic [31:0]            guard_base;
    logic                   is_due;
    logic                   fire_ok;
    logic                   wr_en;
    entry_t                 wr_data;
    logic                   clr_en;
    logic [SLOT_W-1:0]      clr_idx;
    logic                   emit;
    logic                   emit_next;
    rsp_t                   rsp_next;

    stq_store #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_idx  (free_slot_reg),
        .wr_data (wr_data),
        .rd_idx  (cnt_reg[SLOT_W-1:0]),
        .rd_data (rd_data),
        .clr_en  (clr_en),
        .clr_idx (clr_idx),
        .valid   (valid)
    );

    stq_cmp u_cmp (
        .ent         (rd_data),
        .now_ticks   (cmd_reg.now_ticks),
        .callback_id (cmd_reg.callback_id),
        .context_id  (cmd_reg.context_id),
        .best_key    (best_key_reg),
        .res         (res)
    );

    always_comb
    begin
        slot_v     = valid[pipe_idx_reg];
        delay_eff  = (cmd_reg.delay == '0) ? 31'd1 : cmd_reg.delay;
        when_ticks = cmd_reg.now_ticks + {1'b0, delay_eff};
        // The new timer's distance from now is delay_eff, always positive.
        new_key    = {1'b1, delay_eff};
        new_earliest = !have_best_reg || (new_key < best_key_reg)
                       || ((new_key == best_key_reg) && (free_slot_reg < best_slot_reg));

        // A timer is due once now, seen from the guard point before its set
        // time, has gone past its due time.
        guard_base = best_ent_reg.set_time - GUARD;
        is_due     = (cmd_reg.now_ticks - guard_base) > (best_ent_reg.due - guard_base);
        fire_ok    = have_best_reg && (fires_reg < FIRE_LIM) && is_due;

        wr_en               = (state_reg == S_SCHED_END) && !found_reg && free_reg;
        wr_data.callback_id = cmd_reg.callback_id;
        wr_data.context_id  = cmd_reg.context_id;
        wr_data.due         = when_ticks;
        wr_data.set_time    = cmd_reg.now_ticks;

        clr_en  = ((state_reg == S_SCAN) && pipe_vld_reg && (cmd_reg.opcode == OP_EXPIRE)
                   && slot_v && res.ctx_hit)
                  || ((state_reg == S_RUN_CHECK) && fire_ok);
        clr_idx = (state_reg == S_RUN_CHECK) ? best_slot_reg : pipe_idx_reg;
    end

    // Result assembly; fields that mean nothing for a kind stay zero.
    always_comb
    begin
        rsp_next  = '0;
        emit_next = 1'b0;
        unique case (state_reg)
            S_SCHED_END:
            begin
                emit_next                = 1'b1;
                rsp_next.kind            = KIND_SCHED;
                rsp_next.callback_id_out = cmd_reg.callback_id;
                rsp_next.context_id_out  = cmd_reg.context_id;
                rsp_next.time_value      = when_ticks;
                rsp_next.last            = 1'b1;
                priority if (found_reg)
                begin
                    rsp_next.status      = ST_PRESENT;
                    rsp_next.is_earliest = best_slot_reg == found_slot_reg;
                end
                else if (!free_reg)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    rsp_next.status      = ST_ADDED;
                    rsp_next.is_earliest = new_earliest;
                end
            end
            S_RUN_CHECK:
            begin
                emit_next = 1'b1;
                priority if (fire_ok)
                begin
                    rsp_next.kind            = KIND_FIRED;
                    rsp_next.callback_id_out = best_ent_reg.callback_id;
                    rsp_next.context_id_out  = best_ent_reg.context_id;
                    rsp_next.time_value      = best_ent_reg.due;
                end
                else if (have_best_reg)
                begin
                    rsp_next.kind       = KIND_RUN_DONE;
                    rsp_next.time_value = best_ent_reg.due;
                    rsp_next.pending    = 1'b1;
                    rsp_next.last       = 1'b1;
                end
                else
                begin
                    rsp_next.kind = KIND_RUN_DONE;
                    rsp_next.last = 1'b1;
                end
            end
            S_EXP_END:
            begin
                emit_next              = 1'b1;
                rsp_next.kind          = KIND_EXP_DONE;
                rsp_next.removed_count = rm_cnt_reg;
                rsp_next.last          = 1'b1;
            end
            default:
            begin
                emit_next = 1'b0;
            end
        endcase
        emit = emit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            have_best_reg <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            rm_cnt_reg    <= '0;
            fires_reg     <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg   <= emit;
            // A slot read is issued on every walk cycle that still has a slot left.
            pipe_vld_reg <= (state_reg == S_SCAN) && (cnt_reg < SLOT_CNT);
            if (emit)
            begin
                rsp_reg <= rsp_next;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg       <= cmd;
                        cnt_reg       <= '0;
                        have_best_reg <= 1'b0;
                        found_reg     <= 1'b0;
                        free_reg      <= 1'b0;
                        rm_cnt_reg    <= '0;
                        fires_reg     <= '0;
                        if (cmd.opcode != OP_NONE)
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // Read of the next slot is in flight while the previous
                    // slot's data goes through the compare unit.
                    if (cnt_reg < SLOT_CNT)
                    begin
                        pipe_idx_reg <= cnt_reg[SLOT_W-1:0];
                        cnt_reg      <= cnt_reg + 1'b1;
                    end
                    if (pipe_vld_reg)
                    begin
                        // Strictly earlier only, so ties keep the lower slot.
                        if (slot_v && (!have_best_reg || res.earlier))
                        begin
                            have_best_reg <= 1'b1;
                            best_slot_reg <= pipe_idx_reg;
                            best_key_reg  <= res.order_key;
                            best_ent_reg  <= rd_data;
                        end
                        if (slot_v && res.key_hit && !found_reg)
                        begin
                            found_reg      <= 1'b1;
                            found_slot_reg <= pipe_idx_reg;
                        end
                        if (!slot_v && !free_reg)
                        begin
                            free_reg      <= 1'b1;
                            free_slot_reg <= pipe_idx_reg;
                        end
                        if (clr_en && (rm_cnt_reg != RM_CNT_MAX))
                        begin
                            rm_cnt_reg <= rm_cnt_reg + 1'b1;
                        end
                    end
                    if (cnt_reg == SLOT_CNT)
                    begin
                        unique case (cmd_reg.opcode)
                            OP_SCHEDULE: state_reg <= S_SCHED_END;
                            OP_RUN:      state_reg <= S_RUN_CHECK;
                            default:     state_reg <= S_EXP_END;
                        endcase
                    end
                end
                S_SCHED_END:
                begin
                    state_reg <= S_IDLE;
                end
                S_RUN_CHECK:
                begin
                    if (fire_ok)
                    begin
                        // The fired slot is cleared now; walk the table again.
                        cnt_reg       <= '0;
                        have_best_reg <= 1'b0;
                        fires_reg     <= fires_reg + 1'b1;
                        state_reg     <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EXP_END:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign strobe = strobe_reg;
    assign rsp    = rsp_reg;

    // The final transfer of a command coincides with the block going idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && rsp.last |-> !busy)
        else $error("final result while still busy");

    // A fired timer is always followed by more work on the same run.
    a_fired_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !rsp.last |-> busy && (rsp.kind == KIND_FIRED))
        else $error("non-final result that is not a fired timer");

    // A valid command always enters the table walk.
    a_start_walk: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.opcode != OP_NONE) |=> busy)
        else $error("accepted command did not start");

    a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
        fires_reg <= FIRE_LIM)
        else $error("fire count beyond limit");

    a_sched_status: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (rsp.kind == KIND_SCHED)
        |-> ((rsp.status == ST_ADDED) || (rsp.status == ST_PRESENT)
             || (rsp.status == ST_FULL)) && !rsp.pending)
        else $error("bad schedule answer");

endmodule
